// File: hdl/sqmm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sqmm_pkg
// Shared types and constants for the square matrix multiplier.
// ----------------------------------------------------------------------------
package sqmm_pkg;

    localparam int DEF_MAX_N      = 16;
    localparam int DEF_ELEM_WIDTH = 16;

    localparam int IDX_W       = 4;   // row / column index fields
    localparam int SIZE_W      = 5;   // size_in_use register
    localparam int ACC_W       = 40;  // accumulator and result word
    localparam int QUEUE_DEPTH = 2;

    localparam int REG_IDX_W = 1;
    localparam int PADDR_W   = REG_IDX_W + 2;
    localparam int PDATA_W   = 32;

    localparam logic [REG_IDX_W-1:0] REG_SIZE_IN_USE = 1'b0;

    typedef enum logic [0:0] {
        OP_LOAD_B = 1'b0,
        OP_A      = 1'b1
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } item_meta_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_EMIT_RD,
        ST_EMIT_LD
    } back_state_t;

endpackage
`default_nettype wire

// File: hdl/sqmm_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sqmm_queue
// Short FIFO between the intake front end and the compute back end.
// ----------------------------------------------------------------------------
module sqmm_queue #(
    parameter int DATA_W = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] din,
    output logic              full,
    output logic              valid,
    output logic [DATA_W-1:0] dout,
    input  logic              pop
);
    import sqmm_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= din;
        end
    end

    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign dout  = mem[rd_ptr_reg];

endmodule
`default_nettype wire

// File: hdl/sqmm_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sqmm_front
// Config register, input intake and range filtering ahead of the queue.
// ----------------------------------------------------------------------------
module sqmm_front #(
    parameter int MAX_N      = sqmm_pkg::DEF_MAX_N,
    parameter int ELEM_WIDTH = sqmm_pkg::DEF_ELEM_WIDTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // APB config
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sqmm_pkg::PADDR_W-1:0]   paddr,
    input  logic [sqmm_pkg::PDATA_W-1:0]   pwdata,
    output logic [sqmm_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    // input words
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_op,
    input  logic [sqmm_pkg::IDX_W-1:0]     s_row,
    input  logic [sqmm_pkg::IDX_W-1:0]     s_col,
    input  logic signed [ELEM_WIDTH-1:0]   s_value,
    // to queue
    output logic                           q_push,
    output sqmm_pkg::item_meta_t           q_meta,
    output logic [ELEM_WIDTH-1:0]          q_value,
    input  logic                           q_full,
    // effective matrix size
    output logic [$clog2(MAX_N+1)-1:0]     n_size
);
    import sqmm_pkg::*;

    localparam int NW = $clog2(MAX_N + 1);
    localparam int CW = (NW > IDX_W) ? NW : IDX_W;
    // reset value clamped to what the register can hold
    localparam logic [SIZE_W-1:0] SIZE_RST =
        (MAX_N >= (1 << SIZE_W)) ? {SIZE_W{1'b1}} : SIZE_W'(MAX_N);

    logic [SIZE_W-1:0]    size_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;
    logic                 in_range;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= SIZE_RST;
        end else if (wr_en && (reg_idx == REG_SIZE_IN_USE)) begin
            size_reg <= pwdata[SIZE_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_idx == REG_SIZE_IN_USE) begin
            prdata = PDATA_W'(size_reg);
        end
    end

    always_comb begin
        if (size_reg == '0) begin
            n_size = NW'(1);
        end else if (int'(size_reg) > MAX_N) begin
            n_size = NW'(MAX_N);
        end else begin
            n_size = NW'(size_reg);
        end
    end

    // out-of-range words are taken and dropped
    assign in_range = (CW'(s_row) < CW'(n_size)) && (CW'(s_col) < CW'(n_size));
    assign s_ready  = !q_full;
    assign q_push   = s_valid && s_ready && in_range;

    assign q_meta.op  = op_t'(s_op);
    assign q_meta.row = s_row;
    assign q_meta.col = s_col;
    assign q_value    = s_value;

endmodule
`default_nettype wire

// File: hdl/sqmm_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sqmm_back
// B store, one MAC unit over a B row, accumulator memory and row emission.
// ----------------------------------------------------------------------------
module sqmm_back #(
    parameter int MAX_N      = sqmm_pkg::DEF_MAX_N,
    parameter int ELEM_WIDTH = sqmm_pkg::DEF_ELEM_WIDTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [$clog2(MAX_N+1)-1:0]          n_size,
    input  logic                                q_valid,
    input  sqmm_pkg::item_meta_t                q_meta,
    input  logic [ELEM_WIDTH-1:0]               q_value,
    output logic                                q_pop,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [sqmm_pkg::IDX_W-1:0]          m_out_row,
    output logic [sqmm_pkg::IDX_W-1:0]          m_out_col,
    output logic signed [sqmm_pkg::ACC_W-1:0]   m_product_sum,
    output logic                                m_last
);
    import sqmm_pkg::*;

    localparam int NW     = $clog2(MAX_N + 1);
    localparam int JW     = $clog2(MAX_N);
    localparam int CW     = (NW > IDX_W) ? NW : IDX_W;
    localparam int DEPTH  = MAX_N * MAX_N;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PW     = 2 * ELEM_WIDTH;

    back_state_t state_reg, state_next;
    logic [JW-1:0] j_reg, j_next;

    logic [IDX_W-1:0]             row_reg, col_reg;
    logic signed [ELEM_WIDTH-1:0] a_reg;

    logic [ELEM_WIDTH-1:0]        b_mem [DEPTH];
    logic signed [ELEM_WIDTH-1:0] b_rd_reg;
    logic [ACC_W-1:0]             acc_mem [MAX_N];
    logic [ACC_W-1:0]             acc_rd_reg;

    logic                 s1_valid_reg, s2_valid_reg;
    logic [JW-1:0]        s1_j_reg, s2_j_reg;
    logic signed [PW-1:0] prod_reg;
    logic [ACC_W-1:0]     acc_hold_reg;
    logic [ACC_W-1:0]     acc_sum;

    logic                     m_valid_reg;
    logic [IDX_W-1:0]         m_out_row_reg, m_out_col_reg;
    logic signed [ACC_W-1:0]  m_product_sum_reg;
    logic                     m_last_reg;

    logic b_we, a_cap, mac_issue, acc_rd_en, out_load;
    logic j_last, col_first, col_last;
    logic [ADDR_W-1:0] b_wr_addr, b_rd_addr;

    assign j_last    = (NW'(j_reg) + NW'(1)) == n_size;
    assign col_first = (col_reg == '0);
    assign col_last  = (CW'(col_reg) + CW'(1)) == CW'(n_size);

    assign b_wr_addr = ADDR_W'(q_meta.row) * ADDR_W'(MAX_N) + ADDR_W'(q_meta.col);
    assign b_rd_addr = ADDR_W'(col_reg) * ADDR_W'(MAX_N) + ADDR_W'(j_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        j_next     = j_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid && (q_meta.op == OP_A)) begin
                    state_next = ST_MAC;
                    j_next     = '0;
                end
            end
            ST_MAC: begin
                j_next = j_reg + JW'(1);
                if (j_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // wait for the last accumulator write-back
                if (!s1_valid_reg && !s2_valid_reg) begin
                    if (col_last) begin
                        state_next = ST_EMIT_RD;
                        j_next     = '0;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                if (!m_valid_reg || m_ready) begin
                    j_next     = j_reg + JW'(1);
                    state_next = j_last ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        q_pop     = 1'b0;
        b_we      = 1'b0;
        a_cap     = 1'b0;
        mac_issue = 1'b0;
        acc_rd_en = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                q_pop = q_valid;
                b_we  = q_valid && (q_meta.op == OP_LOAD_B);
                a_cap = q_valid && (q_meta.op == OP_A);
            end
            ST_MAC: begin
                mac_issue = 1'b1;
                acc_rd_en = 1'b1;
            end
            ST_EMIT_RD: begin
                acc_rd_en = 1'b1;
            end
            ST_EMIT_LD: begin
                out_load = !m_valid_reg || m_ready;
            end
            default: begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            j_reg        <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            j_reg        <= j_next;
            s1_valid_reg <= mac_issue;
            s2_valid_reg <= s1_valid_reg;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_cap) begin
            row_reg <= q_meta.row;
            col_reg <= q_meta.col;
            a_reg   <= q_value;
        end
        s1_j_reg     <= j_reg;
        s2_j_reg     <= s1_j_reg;
        prod_reg     <= a_reg * b_rd_reg;
        acc_hold_reg <= acc_rd_reg;
        if (out_load) begin
            m_out_row_reg     <= row_reg;
            m_out_col_reg     <= IDX_W'(j_reg);
            m_product_sum_reg <= acc_rd_reg;
            m_last_reg        <= j_last;
        end
    end

    // B store
    always_ff @(posedge aclk) begin
        if (b_we) begin
            b_mem[b_wr_addr] <= q_value;
        end
        if (mac_issue) begin
            b_rd_reg <= b_mem[b_rd_addr];
        end
    end

    // k = 0 starts a fresh row sum
    assign acc_sum = (col_first ? '0 : acc_hold_reg) + ACC_W'(prod_reg);

    always_ff @(posedge aclk) begin
        if (s2_valid_reg) begin
            acc_mem[s2_j_reg] <= acc_sum;
        end
        if (acc_rd_en) begin
            acc_rd_reg <= acc_mem[j_reg];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_row     = m_out_row_reg;
    assign m_out_col     = m_out_col_reg;
    assign m_product_sum = m_product_sum_reg;
    assign m_last        = m_last_reg;

`ifndef SYNTHESIS
    a_wb_in_mac: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_valid_reg |-> (state_reg == ST_MAC || state_reg == ST_DRAIN))
        else $error("accumulator write-back outside MAC phase");

    a_j_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MAC || state_reg == ST_EMIT_RD) |-> (NW'(j_reg) < n_size))
        else $error("column counter beyond matrix size");

    a_no_raw: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MAC && s2_valid_reg) |-> (s2_j_reg != j_reg))
        else $error("accumulator read collides with pending write");

    a_pipe_step: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg |=> s2_valid_reg)
        else $error("MAC pipeline lost a stage");
`endif

endmodule
`default_nettype wire

// File: hdl/square_matrix_multiply.sv
`default_nettype none
// Flow: a B word is written at the edge that takes it from the queue; an A word
// occupies the back end for its dequeue, MAC issues over a B row and a drain. After
// the A word with k = n-1, the row of C follows word by word, stalling on m_ready.
// B words go back to back, A words one at a time; the queue holds 2 words.
// Reset (aresetn low, synchronous): control cleared, size_in_use = MAX_N;
// B store and accumulators are not cleared.
// ----------------------------------------------------------------------------
// square_matrix_multiply
// C = A * B for square Q1.15 matrices with 40-bit Q.30 row accumulators.
// ----------------------------------------------------------------------------
module square_matrix_multiply #(
    parameter int MAX_N      = sqmm_pkg::DEF_MAX_N,
    parameter int ELEM_WIDTH = sqmm_pkg::DEF_ELEM_WIDTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sqmm_pkg::PADDR_W-1:0]        paddr,
    input  logic [sqmm_pkg::PDATA_W-1:0]        pwdata,
    output logic [sqmm_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_op,
    input  logic [sqmm_pkg::IDX_W-1:0]          s_row,
    input  logic [sqmm_pkg::IDX_W-1:0]          s_col,
    input  logic signed [ELEM_WIDTH-1:0]        s_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [sqmm_pkg::IDX_W-1:0]          m_out_row,
    output logic [sqmm_pkg::IDX_W-1:0]          m_out_col,
    output logic signed [sqmm_pkg::ACC_W-1:0]   m_product_sum,
    output logic                                m_last
);
    import sqmm_pkg::*;

    localparam int NW     = $clog2(MAX_N + 1);
    localparam int META_W = $bits(item_meta_t);
    localparam int Q_W    = META_W + ELEM_WIDTH;

    logic                  q_push, q_full, q_valid, q_pop;
    item_meta_t            q_meta_in, q_meta_out;
    logic [ELEM_WIDTH-1:0] q_value_in, q_value_out;
    logic [Q_W-1:0]        q_dout;
    logic [NW-1:0]         n_size;

    sqmm_front #(
        .MAX_N      (MAX_N),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_op),
        .s_row   (s_row),
        .s_col   (s_col),
        .s_value (s_value),
        .q_push  (q_push),
        .q_meta  (q_meta_in),
        .q_value (q_value_in),
        .q_full  (q_full),
        .n_size  (n_size)
    );

    sqmm_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     ({q_meta_in, q_value_in}),
        .full    (q_full),
        .valid   (q_valid),
        .dout    (q_dout),
        .pop     (q_pop)
    );

    assign q_meta_out  = item_meta_t'(q_dout[Q_W-1:ELEM_WIDTH]);
    assign q_value_out = q_dout[ELEM_WIDTH-1:0];

    sqmm_back #(
        .MAX_N      (MAX_N),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .n_size        (n_size),
        .q_valid       (q_valid),
        .q_meta        (q_meta_out),
        .q_value       (q_value_out),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_row     (m_out_row),
        .m_out_col     (m_out_col),
        .m_product_sum (m_product_sum),
        .m_last        (m_last)
    );

endmodule
`default_nettype wire
